// File: design/source_map_mappings_decoder_defines.svh
// assertion macros for the mappings decoder rtl, used by smmd_decode
// expects signals named clk and rst_n in the module that uses them
`ifndef SOURCE_MAP_MAPPINGS_DECODER_DEFINES_SVH
`define SOURCE_MAP_MAPPINGS_DECODER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define SMMD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SMMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/smmd_pkg.sv
// shared types, constants and the base64 digit table for the mappings decoder
// no dependencies
package smmd_pkg;

  localparam int DATA_W  = 32;          // running value and accumulator width
  localparam int SHIFT_W = 6;           // holds shift positions up to DATA_W + DIG_PAY
  localparam int FC_W    = 3;           // field counter width
  localparam int DIG_PAY = 5;           // payload bits per base64 digit
  localparam int CONT_B  = 5;           // continuation flag bit in a digit

  localparam logic [FC_W-1:0] FIELD_MAX = 3'd5;
  localparam logic [FC_W-1:0] FLD_COL   = 3'd0;
  localparam logic [FC_W-1:0] FLD_SRC   = 3'd1;
  localparam logic [FC_W-1:0] FLD_OLINE = 3'd2;
  localparam logic [FC_W-1:0] FLD_OCOL  = 3'd3;
  localparam logic [FC_W-1:0] FLD_REC   = 3'd2;  // fewest fields that give a record

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  localparam logic [SHIFT_W-1:0] SHIFT_LIM = SHIFT_W'(DATA_W);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(DATA_W + DIG_PAY - 1);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gen_line;
    logic signed [DATA_W-1:0] gen_col;
    logic signed [DATA_W-1:0] source_index;
    logic signed [DATA_W-1:0] orig_line;
    logic signed [DATA_W-1:0] orig_col;
  } rec_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64_t;

  // base64 alphabet lookup
  function automatic b64_t b64_digit(input logic [7:0] c);
    b64_t r;
    r = '0;
    case (c) inside
      [8'h41:8'h5A]: r = '{valid: 1'b1, value: 6'(c - 8'h41)};
      [8'h61:8'h7A]: r = '{valid: 1'b1, value: 6'(c - 8'h61 + 8'd26)};
      [8'h30:8'h39]: r = '{valid: 1'b1, value: 6'(c - 8'h30 + 8'd52)};
      8'h2B:         r = '{valid: 1'b1, value: 6'd62};
      8'h2F:         r = '{valid: 1'b1, value: 6'd63};
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/source_map_mappings_decoder.sv
// top level of the source map mappings decoder
// depends on smmd_pkg, smmd_in_stage, smmd_decode and smmd_out_stage
//
// Usage:
//   in channel: one character of the mappings text per request (in_ch), with
//   in_last high on the final character. out channel: one mapping record per
//   request (generated line and column, source index, original line and
//   column), given when a segment of two or more fields ends at ',' or ';'
//   or at the end of the text.
//   out_valid rises once the character that ends its segment has passed the
//   input register and its record has been loaded into the result register.
//   Throughput: one character per cycle unless stalled; the per-character path
//   is digit lookup, vlq sign fold and one shared 32-bit running-value adder.
//   Reset: running lines restart at one, columns and source index at zero,
//   no value or segment open, both registers empty. The decoder state restarts
//   the same way after the character marked last.
//   Stall: while out_ready is low with a record waiting, the decoder holds;
//   in_ready is high only while the input register is empty or being taken.
module source_map_mappings_decoder import smmd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_ch,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_gen_line,
  output logic signed [DATA_W-1:0] out_gen_col,
  output logic signed [DATA_W-1:0] out_source_index,
  output logic signed [DATA_W-1:0] out_orig_line,
  output logic signed [DATA_W-1:0] out_orig_col
);

  item_t in_item, s1_item;
  logic  s1_valid, adv, space, emit;
  rec_t  rec, out_rec;

  assign in_item.ch   = in_ch;
  assign in_item.last = in_last;

  // decoder moves when the result register has room
  assign adv = s1_valid && space;

  smmd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  smmd_decode u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item),
    .emit  (emit),
    .rec   (rec)
  );

  smmd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && emit),
    .rec       (rec),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign out_gen_line     = out_rec.gen_line;
  assign out_gen_col      = out_rec.gen_col;
  assign out_source_index = out_rec.source_index;
  assign out_orig_line    = out_rec.orig_line;
  assign out_orig_col     = out_rec.orig_col;

endmodule

// File: design/smmd_in_stage.sv
// input register of the mappings decoder: holds one character request
// depends on smmd_pkg
module smmd_in_stage import smmd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  adv,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // stage empties when the decoder takes it
  assign in_ready  = !valid_r || adv;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: design/smmd_decode.sv
// vlq gathering, running values and segment handling for one character
// depends on smmd_pkg and source_map_mappings_decoder_defines.svh
`include "source_map_mappings_decoder_defines.svh"

module smmd_decode import smmd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  output logic  emit,
  output rec_t  rec
);

  logic [DATA_W-1:0]  line_r, col_r, src_r, oline_r, ocol_r, acc_r;
  logic [DATA_W-1:0]  line_nxt, col_nxt, src_nxt, oline_nxt, ocol_nxt, acc_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [FC_W-1:0]    fc_r, fc_nxt;

  b64_t               dig;
  logic               is_sep, is_semi, take;
  logic [DATA_W-1:0]  acc_add, mag, delta, tgt, sum;
  logic [SHIFT_W-1:0] shift_add;
  logic [DATA_W-1:0]  col_m, src_m, oline_m, ocol_m, acc_m;
  logic [SHIFT_W-1:0] shift_m;
  logic [FC_W-1:0]    fc_m;
  logic               seg_emit;

  // character class
  assign dig     = b64_digit(item.ch);
  assign is_semi = (item.ch == CHAR_SEMI);
  assign is_sep  = (item.ch == CHAR_COMMA) || is_semi;

  // digit gathering, payload dropped once the value is full
  always_comb begin
    if (shift_r < SHIFT_LIM) begin
      acc_add   = acc_r | (DATA_W'(dig.value[DIG_PAY-1:0]) << shift_r);
      shift_add = shift_r + SHIFT_W'(DIG_PAY);
    end else begin
      acc_add   = acc_r;
      shift_add = shift_r;
    end
  end

  // sign sits in bit 0
  assign mag   = acc_add >> 1;
  assign delta = (!dig.valid) ? '0 : (acc_add[0] ? (DATA_W'(0) - mag) : mag);
  assign take  = !is_sep && (!dig.valid || !dig.value[CONT_B]);

  // one adder shared by the four running values
  always_comb begin
    case (fc_r)
      FLD_COL:   tgt = col_r;
      FLD_SRC:   tgt = src_r;
      FLD_OLINE: tgt = oline_r;
      FLD_OCOL:  tgt = ocol_r;
      default:   tgt = '0;
    endcase
  end
  assign sum = tgt + delta;

  // state once the character's field is taken, before segment end
  always_comb begin
    col_m   = col_r;
    src_m   = src_r;
    oline_m = oline_r;
    ocol_m  = ocol_r;
    acc_m   = acc_r;
    shift_m = shift_r;
    fc_m    = fc_r;
    if (take) begin
      case (fc_r)
        FLD_COL:   col_m   = sum;
        FLD_SRC:   src_m   = sum;
        FLD_OLINE: oline_m = sum;
        FLD_OCOL:  ocol_m  = sum;
        default:   ;
      endcase
      acc_m   = '0;
      shift_m = '0;
      fc_m    = (fc_r == FIELD_MAX) ? FIELD_MAX : fc_r + FC_W'(1);
    end else if (!is_sep) begin
      acc_m   = acc_add;
      shift_m = shift_add;
    end
  end

  // an unfinished value at segment end counts as one more field
  assign seg_emit = (fc_m >= FLD_REC) || ((fc_m == FLD_REC - FC_W'(1)) && (shift_m != '0));
  assign emit     = (is_sep || item.last) && seg_emit;

  assign rec.gen_line     = $signed(line_r);
  assign rec.gen_col      = $signed(col_m);
  assign rec.source_index = $signed(src_m);
  assign rec.orig_line    = $signed(oline_m);
  assign rec.orig_col     = $signed(ocol_m);

  // segment end and end of text
  always_comb begin
    line_nxt  = line_r;
    col_nxt   = col_m;
    src_nxt   = src_m;
    oline_nxt = oline_m;
    ocol_nxt  = ocol_m;
    acc_nxt   = acc_m;
    shift_nxt = shift_m;
    fc_nxt    = fc_m;
    if (item.last) begin
      line_nxt  = DATA_W'(1);
      col_nxt   = '0;
      src_nxt   = '0;
      oline_nxt = DATA_W'(1);
      ocol_nxt  = '0;
      acc_nxt   = '0;
      shift_nxt = '0;
      fc_nxt    = '0;
    end else if (is_sep) begin
      acc_nxt   = '0;
      shift_nxt = '0;
      fc_nxt    = '0;
      if (is_semi) begin
        line_nxt = line_r + DATA_W'(1);
        col_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= DATA_W'(1);
      col_r   <= '0;
      src_r   <= '0;
      oline_r <= DATA_W'(1);
      ocol_r  <= '0;
      acc_r   <= '0;
      shift_r <= '0;
      fc_r    <= '0;
    end else if (fire) begin
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      src_r   <= src_nxt;
      oline_r <= oline_nxt;
      ocol_r  <= ocol_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      fc_r    <= fc_nxt;
    end
  end

  // checks
  `SMMD_ASSERT_ALWAYS(a_fc_sat, fc_r <= FIELD_MAX, "field count past saturation")
  `SMMD_ASSERT_ALWAYS(a_shift_lim, shift_r <= SHIFT_MAX, "vlq shift past limit")
  `SMMD_ASSERT_NEXT(a_last_clears, fire && item.last, (fc_r == '0) && (shift_r == '0) && (line_r == DATA_W'(1)) && (oline_r == DATA_W'(1)), "state not restored after end of text")
  `SMMD_ASSERT_NEXT(a_semi_col, fire && is_semi, (col_r == '0) && (fc_r == '0), "semicolon did not clear column")

endmodule

// File: design/smmd_out_stage.sv
// result register of the mappings decoder: holds one mapping record request
// depends on smmd_pkg
module smmd_out_stage import smmd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  rec_t rec,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output rec_t out_rec
);

  logic valid_r, valid_nxt;
  rec_t rec_r;

  // free when empty or being drained this cycle
  assign space     = !valid_r || out_ready;
  assign valid_nxt = space ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      rec_r <= rec;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = rec_r;

endmodule
